FILE: sv/sacl_pkg.sv
package sacl_pkg;

	localparam int ADDR_W    = 31;
	localparam int BW_W      = 17;
	localparam int SC_W      = 7;
	localparam int WC_W      = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 17;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WORDS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAY_COUNT   = 2'd2;

	// action codes
	localparam logic ACT_ACCESS = 1'b0;
	localparam logic ACT_PROBE  = 1'b1;

endpackage

FILE: sv/sacl_if.sv
interface sacl_in_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [sacl_pkg::ADDR_W-1:0] address;

	modport source (output valid, action, address, input ready);
	modport sink   (input valid, action, address, output ready);
endinterface

interface sacl_out_if;
	logic valid;
	logic ready;
	logic hit;
	logic evicted;

	modport source (output valid, hit, evicted, input ready);
	modport sink   (input valid, hit, evicted, output ready);
endinterface

FILE: sv/sacl_div.sv
module sacl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sacl_pkg::ADDR_W-1:0] dividend,
	input  logic [sacl_pkg::BW_W-1:0]   divisor,
	output logic                        done,
	output logic [sacl_pkg::ADDR_W-1:0] quotient,
	output logic [sacl_pkg::BW_W-1:0]   remainder
);
	localparam int QW = sacl_pkg::ADDR_W;
	localparam int RW = sacl_pkg::BW_W;
	localparam int CW = $clog2(QW);
	localparam logic [CW-1:0] LAST = CW'(QW - 1);

	logic [RW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [RW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [RW:0]   sh;
	logic [RW:0]   diff;
	logic          ge;

	// one quotient bit per cycle, restoring
	assign sh   = {rem_q, quo_q[QW-1]};
	assign ge   = sh >= {1'b0, dvs_q};
	assign diff = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[RW-1:0] : sh[RW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

FILE: sv/set_assoc_cache_lru_tags_core.sv
// Tag store of a set-associative cache with counter-based LRU replacement.
// in_ch: one transaction per memory reference (action, address); action
//   access updates the set, action probe only looks up.
// out_ch: one transaction per reference (hit, evicted), in order.
// Config: cfg_we/cfg_index/cfg_data write block_words, set_count, way_count;
//   write them only while the block is idle.
// Sequence: each in_ch transaction goes through two passes of the shared
//   bit-serial divider (address / block size, then block / sets), then the
//   set row read, then the update and write back, before out_ch.valid rises.
// in_ch.ready is high only when idle, so a new reference is taken only after
//   the previous one has finished its update.
// The result sits in an output register; a new reference is taken while it
//   waits, but the update stalls until out_ch takes the previous result.
// Reset: after arst_n rises the set memory is cleared one row per cycle,
//   all MAX_SETS rows, while in_ch.ready stays low. Config writes are taken.
module set_assoc_cache_lru_tags_core #(
	parameter int MAX_SETS = 64,
	parameter int MAX_WAYS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sacl_pkg::CFG_W-1:0]     cfg_data,
	sacl_in_if.sink                        in_ch,
	sacl_out_if.source                     out_ch
);
	localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int AGE_W   = WAY_W;
	localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
	localparam int ADDR_W  = sacl_pkg::ADDR_W;
	localparam int BW_W    = sacl_pkg::BW_W;

	typedef struct packed {
		logic             valid;
		logic [AGE_W-1:0] age;
		logic [ADDR_W-1:0] tag;
	} line_t;

	typedef enum logic [5:0] {
		ST_CLR  = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_DIV1 = 6'b000100,
		ST_DIV2 = 6'b001000,
		ST_READ = 6'b010000,
		ST_EVAL = 6'b100000
	} state_t;

	state_t state_q;

	logic [BW_W-1:0]          block_words_q;
	logic [sacl_pkg::SC_W-1:0] set_count_q;
	logic [sacl_pkg::WC_W-1:0] way_count_q;

	logic [SET_W-1:0]  clr_idx_q;
	logic              action_q;
	logic [ADDR_W-1:0] tag_q;
	logic [SET_W-1:0]  set_q;
	line_t [MAX_WAYS-1:0] rd_row_q;
	line_t [MAX_WAYS-1:0] row_mem [MAX_SETS];

	logic              out_valid_q;
	logic              hit_q;
	logic              evicted_q;

	// effective configuration
	logic [BW_W-1:0]   bw_eff;
	logic [BW_W-1:0]   sets_eff;
	logic [WCNT_W-1:0] ways_eff;

	// divider hookup
	logic              div_start;
	logic [ADDR_W-1:0] div_dividend;
	logic [BW_W-1:0]   div_divisor;
	logic              div_done;
	logic [ADDR_W-1:0] div_quo;
	logic [BW_W-1:0]   div_rem;

	// evaluation
	logic [MAX_WAYS-1:0]  in_use;
	logic                 hit;
	logic                 has_inv;
	logic [WAY_W-1:0]     hit_way;
	logic [WAY_W-1:0]     inv_way;
	logic [WAY_W-1:0]     vic_way;
	logic [WAY_W-1:0]     tw;
	logic [AGE_W-1:0]     old_age;
	line_t [MAX_WAYS-1:0] new_row;
	logic                 in_acc;
	logic                 fire;

	always_comb begin
		bw_eff = (block_words_q == '0) ? BW_W'(1) : block_words_q;
		if (set_count_q == '0)
			sets_eff = BW_W'(1);
		else if (BW_W'(set_count_q) > BW_W'(MAX_SETS))
			sets_eff = BW_W'(MAX_SETS);
		else
			sets_eff = BW_W'(set_count_q);
		if (way_count_q == '0)
			ways_eff = WCNT_W'(1);
		else if (32'(way_count_q) > 32'(MAX_WAYS))
			ways_eff = WCNT_W'(MAX_WAYS);
		else
			ways_eff = WCNT_W'(way_count_q);
	end

	assign in_acc    = in_ch.valid && in_ch.ready;
	assign div_start = in_acc || ((state_q == ST_DIV1) && div_done);
	assign div_dividend = (state_q == ST_IDLE) ? in_ch.address : div_quo;
	assign div_divisor  = (state_q == ST_IDLE) ? bw_eff : sets_eff;

	sacl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// hit / fill / victim selection and LRU age update for the read row
	always_comb begin
		hit     = 1'b0;
		has_inv = 1'b0;
		hit_way = '0;
		inv_way = '0;
		vic_way = '0;
		for (int i = 0; i < MAX_WAYS; i++)
			in_use[i] = 32'(i) < 32'(ways_eff);
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (in_use[i] && rd_row_q[i].valid && rd_row_q[i].tag == tag_q) begin
				hit     = 1'b1;
				hit_way = WAY_W'(i);
			end
			if (in_use[i] && !rd_row_q[i].valid) begin
				has_inv = 1'b1;
				inv_way = WAY_W'(i);
			end
		end
		for (int i = 1; i < MAX_WAYS; i++)
			if (in_use[i] && rd_row_q[i].age < rd_row_q[vic_way].age)
				vic_way = WAY_W'(i);
		tw      = hit ? hit_way : (has_inv ? inv_way : vic_way);
		old_age = rd_row_q[tw].age;
		new_row = rd_row_q;
		for (int i = 0; i < MAX_WAYS; i++)
			if (in_use[i] && rd_row_q[i].valid && rd_row_q[i].age > old_age)
				new_row[i].age = rd_row_q[i].age - 1'b1;
		new_row[tw].valid = 1'b1;
		new_row[tw].tag   = tag_q;
		new_row[tw].age   = AGE_W'(ways_eff - 1'b1);
	end

	assign fire = (state_q == ST_EVAL) && (!out_valid_q || out_ch.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_words_q <= BW_W'(1);
			set_count_q   <= 7'd64;
			way_count_q   <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				sacl_pkg::REG_BLOCK_WORDS: block_words_q <= cfg_data[BW_W-1:0];
				sacl_pkg::REG_SET_COUNT:   set_count_q   <= cfg_data[sacl_pkg::SC_W-1:0];
				sacl_pkg::REG_WAY_COUNT:   way_count_q   <= cfg_data[sacl_pkg::WC_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == SET_W'(MAX_SETS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_done)
						state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_done)
						state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (fire)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc)
			action_q <= in_ch.action;
		if ((state_q == ST_DIV2) && div_done) begin
			tag_q <= div_quo;
			set_q <= div_rem[SET_W-1:0];
		end
		if (fire) begin
			hit_q     <= hit;
			evicted_q <= !hit && !has_inv && (action_q == sacl_pkg::ACT_ACCESS);
		end
	end

	// set memory: one row holds all ways of a set
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR)
			row_mem[clr_idx_q] <= '0;
		else if (fire && action_q == sacl_pkg::ACT_ACCESS)
			row_mem[set_q] <= new_row;
		if (state_q == ST_READ)
			rd_row_q <= row_mem[set_q];
	end

	assign in_ch.ready    = (state_q == ST_IDLE);
	assign out_ch.valid   = out_valid_q;
	assign out_ch.hit     = hit_q;
	assign out_ch.evicted = evicted_q;
endmodule
